>>> sv/ffil_pkg.sv
// shared constants and codes for the first free interval lane block
`default_nettype none
package ffil_pkg;

    localparam int ENTRIES_DEF   = 32;
    localparam int TIME_BITS_DEF = 48;

    localparam int IDX_FIELD_W = 5;
    localparam int LANE_W      = 6;
    localparam int IGN_W       = 6;
    localparam int MAP_W       = 64;
    localparam int OUT_W       = 8;

    typedef enum logic {
        FUNC_WRITE = 1'b0,
        FUNC_QUERY = 1'b1
    } t_func;

endpackage
`default_nettype wire

>>> sv/ffil_ram.sv
// generic simple dual port ram with registered read
`default_nettype none
module ffil_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

>>> sv/first_free_interval_lane.sv
// first free interval lane: a table of time intervals with a lowest-free-lane search
// A write transaction (tuser = 0) loads or clears one table entry and
// returns nothing; indexes at or beyond ENTRIES are dropped. A query transaction
// (tuser = 1) returns the lowest lane on which no valid entry, other than the one named
// by ignore_index, overlaps [query_start, query_start + query_duration). While a query
// scans, the entry table ram delivers one entry per cycle to the overlap compare. Input
// is held off while a query runs; a finished result waits in the output register while
// the next transaction is taken.
`default_nettype none
module first_free_interval_lane #(
    parameter int ENTRIES   = ffil_pkg::ENTRIES_DEF,
    parameter int TIME_BITS = ffil_pkg::TIME_BITS_DEF,
    localparam int IN_BITS  = ffil_pkg::IDX_FIELD_W + 1 + ffil_pkg::LANE_W
                              + 4 * TIME_BITS + ffil_pkg::IGN_W,
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    // entry_index, entry_valid, entry_lane, entry_start, entry_end,
    // query_start, query_duration, ignore_index, zero fill
    input  wire logic [IN_W-1:0]             s_axis_tdata,
    // func
    input  wire logic                        s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // free_lane, zero fill
    output logic      [ffil_pkg::OUT_W-1:0]  m_axis_tdata
);
    import ffil_pkg::*;

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int DATA_W = LANE_W + 2 * TIME_BITS;

    localparam int P_IDX   = 0;
    localparam int P_VAL   = P_IDX + IDX_FIELD_W;
    localparam int P_LANE  = P_VAL + 1;
    localparam int P_START = P_LANE + LANE_W;
    localparam int P_END   = P_START + TIME_BITS;
    localparam int P_QS    = P_END + TIME_BITS;
    localparam int P_QD    = P_QS + TIME_BITS;
    localparam int P_IGN   = P_QD + TIME_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ENCODE
    } t_state;

    t_state                 r_state;
    logic [ENTRIES-1:0]     r_valid;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_pend;
    logic [IDX_W-1:0]       r_pidx;
    logic [TIME_BITS-1:0]   r_qs;
    logic [TIME_BITS:0]     r_qe;
    logic [IGN_W-1:0]       r_ign;
    logic [MAP_W-1:0]       r_busy;
    logic                   r_ovalid;
    logic [LANE_W-1:0]      r_olane;

    logic [IDX_FIELD_W-1:0] in_idx;
    logic                   in_val;
    logic [LANE_W-1:0]      in_lane;
    logic [TIME_BITS-1:0]   in_start;
    logic [TIME_BITS-1:0]   in_end;
    logic [TIME_BITS-1:0]   in_qs;
    logic [TIME_BITS-1:0]   in_qd;
    logic [IGN_W-1:0]       in_ign;
    logic [IGN_W-1:0]       wr_idx6;

    logic                   in_xfer;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic [DATA_W-1:0]      rd_data;

    logic [LANE_W-1:0]      ent_lane;
    logic [TIME_BITS-1:0]   ent_start;
    logic [TIME_BITS-1:0]   ent_end;
    logic [IGN_W-1:0]       pidx6;
    logic                   hit;
    logic                   out_free;
    logic [LANE_W-1:0]      enc_lane;

    function automatic logic [LANE_W-1:0] lowest_zero(input logic [MAP_W-1:0] map);
        logic [LANE_W-1:0] res;
        res = LANE_W'(MAP_W - 1);
        for (int k = MAP_W - 1; k >= 0; k--) begin
            if (!map[k]) begin
                res = LANE_W'(k);
            end
        end
        return res;
    endfunction

    assign in_idx   = s_axis_tdata[P_IDX +: IDX_FIELD_W];
    assign in_val   = s_axis_tdata[P_VAL];
    assign in_lane  = s_axis_tdata[P_LANE +: LANE_W];
    assign in_start = s_axis_tdata[P_START +: TIME_BITS];
    assign in_end   = s_axis_tdata[P_END +: TIME_BITS];
    assign in_qs    = s_axis_tdata[P_QS +: TIME_BITS];
    assign in_qd    = s_axis_tdata[P_QD +: TIME_BITS];
    assign in_ign   = s_axis_tdata[P_IGN +: IGN_W];
    assign wr_idx6  = IGN_W'(in_idx);

    assign out_free      = !r_ovalid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    assign wr_en   = in_xfer && (t_func'(s_axis_tuser) == FUNC_WRITE)
                     && (wr_idx6 < IGN_W'(ENTRIES));
    assign wr_addr = wr_idx6[IDX_W-1:0];
    assign rd_en   = (r_state == ST_SCAN) && (r_cnt < CNT_W'(ENTRIES));
    assign rd_addr = r_cnt[IDX_W-1:0];

    ffil_ram #(
        .WIDTH (DATA_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata ({in_end, in_start, in_lane}),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign ent_lane  = rd_data[0 +: LANE_W];
    assign ent_start = rd_data[LANE_W +: TIME_BITS];
    assign ent_end   = rd_data[LANE_W + TIME_BITS +: TIME_BITS];
    assign pidx6     = IGN_W'(r_pidx);
    assign hit       = r_pend && r_valid[r_pidx] && (pidx6 != r_ign)
                       && (r_qs < ent_end) && ({1'b0, ent_start} < r_qe);
    assign enc_lane  = lowest_zero(r_busy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_valid  <= '0;
            r_cnt    <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (wr_en) begin
                r_valid[wr_addr] <= in_val;
            end
            if (hit) begin
                r_busy <= r_busy | (MAP_W'(1) << ent_lane);
            end
            r_pend <= rd_en;
            r_pidx <= rd_addr;
            unique case (r_state)
                ST_IDLE: begin
                    if (in_xfer && (t_func'(s_axis_tuser) == FUNC_QUERY)) begin
                        r_qs    <= in_qs;
                        r_qe    <= {1'b0, in_qs} + {1'b0, in_qd};
                        r_ign   <= in_ign;
                        r_busy  <= '0;
                        r_cnt   <= '0;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (r_cnt == CNT_W'(ENTRIES)) begin
                        r_state <= ST_ENCODE;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                ST_ENCODE: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_olane  <= enc_lane;
                        r_state  <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = OUT_W'(r_olane);

endmodule
`default_nettype wire

>>> verif/ffil_lane_checker.sv
// lane checker: predicts free lanes from observed write and query transactions and compares
`timescale 1ns / 100ps
module ffil_lane_checker #(
    parameter int IN_W = 216
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    input  wire logic                         i_in_ready,
    input  wire logic [IN_W-1:0]              i_in_data,
    input  wire logic                         i_in_func,
    input  wire logic                         i_out_valid,
    input  wire logic                         i_out_ready,
    input  wire logic [ffil_pkg::OUT_W-1:0]   i_out_data,
    output int                                o_fail_count,
    output int                                o_pending
);
    import ffil_pkg::*;

    localparam int TW      = TIME_BITS_DEF;
    localparam int IN_BITS = IDX_FIELD_W + 1 + LANE_W + 4 * TW + IGN_W;

    typedef struct packed {
        logic [IN_W-IN_BITS-1:0]    fill;
        logic [IGN_W-1:0]           ignore_index;
        logic [TW-1:0]              query_duration;
        logic [TW-1:0]              query_start;
        logic [TW-1:0]              entry_end;
        logic [TW-1:0]              entry_start;
        logic [LANE_W-1:0]          entry_lane;
        logic                       entry_valid;
        logic [IDX_FIELD_W-1:0]     entry_index;
    } t_lane_req;

    logic                held      [ENTRIES_DEF];
    logic [LANE_W-1:0]   held_lane [ENTRIES_DEF];
    logic [TW-1:0]       held_from [ENTRIES_DEF];
    logic [TW-1:0]       held_to   [ENTRIES_DEF];
    logic [LANE_W-1:0]   free_lane_q[$];
    int                  fails = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic logic [LANE_W-1:0] first_free_lane(input t_lane_req r);
        logic [MAP_W-1:0]  busy;
        logic [TW:0]       q_end;
        logic [LANE_W-1:0] lane;
        logic              found;
        busy  = '0;
        q_end = {1'b0, r.query_start} + {1'b0, r.query_duration};
        for (int i = 0; i < ENTRIES_DEF; i++) begin
            if (held[i] && i != int'(r.ignore_index) && r.query_start < held_to[i]
                && {1'b0, held_from[i]} < q_end) begin
                busy[held_lane[i]] = 1'b1;
            end
        end
        lane  = '1;
        found = 1'b0;
        for (int k = 0; k < MAP_W; k++) begin
            if (!found && !busy[k]) begin
                lane  = k[LANE_W-1:0];
                found = 1'b1;
            end
        end
        return lane;
    endfunction

    always @(posedge i_clk) begin
        t_lane_req         req;
        logic [LANE_W-1:0] want;
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES_DEF; i++) begin
                held[i] = 1'b0;
            end
            free_lane_q.delete();
        end else begin
            // result side first, so a query taken at this edge is not matched against it
            if (i_out_valid && i_out_ready) begin
                if (free_lane_q.size() == 0) begin
                    $error("free_lane: unexpected transaction, expected none, actual %0d",
                           i_out_data[LANE_W-1:0]);
                    fails++;
                end else begin
                    want = free_lane_q.pop_front();
                    if (i_out_data[LANE_W-1:0] !== want) begin
                        $error("free_lane mismatch: expected %0d, actual %0d",
                               want, i_out_data[LANE_W-1:0]);
                        fails++;
                    end
                    if (i_out_data[OUT_W-1:LANE_W] !== '0) begin
                        $error("tdata fill mismatch: expected 0, actual %0d",
                               i_out_data[OUT_W-1:LANE_W]);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                req = t_lane_req'(i_in_data);
                if (t_func'(i_in_func) == FUNC_QUERY) begin
                    free_lane_q.push_back(first_free_lane(req));
                end else if (int'(req.entry_index) < ENTRIES_DEF) begin
                    held[req.entry_index]      = req.entry_valid;
                    held_lane[req.entry_index] = req.entry_lane;
                    held_from[req.entry_index] = req.entry_start;
                    held_to[req.entry_index]   = req.entry_end;
                end
            end
        end
        o_pending    <= free_lane_q.size();
        o_fail_count <= fails;
    end

endmodule

>>> verif/tb_first_free_interval_lane.sv
// testbench top: drives write and query transactions into the lane block and reports the verdict
`timescale 1ns / 100ps
module tb_first_free_interval_lane;
    import ffil_pkg::*;

    localparam int TW           = TIME_BITS_DEF;
    localparam int IN_BITS      = IDX_FIELD_W + 1 + LANE_W + 4 * TW + IGN_W;
    localparam int IN_W         = ((IN_BITS + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 1150;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam logic [IGN_W-1:0] NO_SKIP = IGN_W'(ENTRIES_DEF);
    localparam logic [TW-1:0]    TMAX    = '1;

    typedef struct packed {
        logic [IN_W-IN_BITS-1:0]    fill;
        logic [IGN_W-1:0]           ignore_index;
        logic [TW-1:0]              query_duration;
        logic [TW-1:0]              query_start;
        logic [TW-1:0]              entry_end;
        logic [TW-1:0]              entry_start;
        logic [LANE_W-1:0]          entry_lane;
        logic                       entry_valid;
        logic [IDX_FIELD_W-1:0]     entry_index;
    } t_lane_req;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata;
    logic              s_axis_tuser;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_W-1:0]  m_axis_tdata;

    int fail_count;
    int pending;
    int items_sent    = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int cycles        = 0;
    int send_pct_tab[4]  = '{0, 80, 0, 11};
    int stall_pct_tab[4] = '{0, 0, 80, 11};

    first_free_interval_lane uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata)
    );

    ffil_lane_checker #(.IN_W(IN_W)) chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (s_axis_tvalid),
        .i_in_ready     (s_axis_tready),
        .i_in_data      (s_axis_tdata),
        .i_in_func      (s_axis_tuser),
        .i_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .i_out_data     (m_axis_tdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [TW-1:0] rand_time();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[TW-1:0];
    endfunction

    function automatic logic [IGN_W-1:0] pick_skip();
        int r;
        r = $urandom_range(9);
        if (r < 7) begin
            return NO_SKIP;
        end else if (r < 9) begin
            return IGN_W'($urandom_range(ENTRIES_DEF - 1));
        end
        return IGN_W'($urandom_range(63, ENTRIES_DEF + 1));
    endfunction

    // valid stays high after acceptance; the caller drives new data or lowers it in the same step
    task automatic push_item(input t_func f, input t_lane_req req);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= f;
        s_axis_tdata  <= req;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic send_write(input logic [IDX_FIELD_W-1:0] idx, input logic ok,
                              input logic [LANE_W-1:0] lane,
                              input logic [TW-1:0] from, input logic [TW-1:0] to);
        t_lane_req req;
        req                = '0;
        req.entry_index    = idx;
        req.entry_valid    = ok;
        req.entry_lane     = lane;
        req.entry_start    = from;
        req.entry_end      = to;
        req.query_start    = rand_time();
        req.query_duration = rand_time();
        req.ignore_index   = IGN_W'($urandom_range(63));
        push_item(FUNC_WRITE, req);
    endtask

    task automatic send_query(input logic [TW-1:0] qs, input logic [TW-1:0] dur,
                              input logic [IGN_W-1:0] skip);
        t_lane_req req;
        req                = '0;
        req.entry_index    = IDX_FIELD_W'($urandom_range(31));
        req.entry_valid    = 1'($urandom_range(1));
        req.entry_lane     = LANE_W'($urandom_range(63));
        req.entry_start    = rand_time();
        req.entry_end      = rand_time();
        req.query_start    = qs;
        req.query_duration = dur;
        req.ignore_index   = skip;
        push_item(FUNC_QUERY, req);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        logic [TW-1:0] base;
        logic [TW-1:0] from;
        logic [TW-1:0] to;
        int            span;
        int            lane_top;
        int            steps;
        int            kind;
        int            phase;
        int            directed_cnt;
        bit            paused_mid;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        paused_mid    = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_query(0, 0, NO_SKIP);
        send_write(0, 1'b1, 0, 100, 200);
        // touching end to end, both sides
        send_query(200, 50, NO_SKIP);
        send_query(50, 50, NO_SKIP);
        // zero duration inside and at the entry start
        send_query(150, 0, NO_SKIP);
        send_query(100, 0, NO_SKIP);
        // empty and reversed entry intervals
        send_write(1, 1'b1, 1, 300, 300);
        send_write(2, 1'b1, 2, 500, 400);
        send_write(31, 1'b1, 63, TMAX - 10, TMAX);
        send_query(0, TMAX, NO_SKIP);
        send_query(0, TMAX, 0);
        send_query(0, TMAX, 6'd63);
        // query end wider than the time field
        send_query(TMAX - 5, TMAX, NO_SKIP);
        send_query(TMAX, TMAX, NO_SKIP);
        send_write(3, 1'b1, 0, 0, TMAX);
        send_query(TMAX - 1, 0, 3);
        send_query(TMAX - 1, 0, 31);
        // clearing writes
        send_write(0, 1'b0, 5, 100, 200);
        send_query(150, 1, NO_SKIP);
        send_write(3, 1'b0, 0, 0, 0);
        send_query(150, 1, NO_SKIP);
        directed_cnt = items_sent;
        wait_drained();

        while (items_sent < directed_cnt + RANDOM_ITEMS) begin
            phase         = (items_sent / 100) % 4;
            send_idle_pct = send_pct_tab[phase];
            stall_pct     = stall_pct_tab[phase];
            kind          = $urandom_range(9);
            if (kind < 6) begin
                // clustered entries and queries inside one small time window
                base     = ($urandom_range(3) == 0) ? TMAX - $urandom_range(2000) : rand_time();
                span     = 1 << $urandom_range(3, 10);
                lane_top = ($urandom_range(3) == 0) ? 63 : $urandom_range(2, 12);
                repeat ($urandom_range(1, 12)) begin
                    from = base + $urandom_range(span);
                    to   = ($urandom_range(7) == 0) ? from - $urandom_range(span)
                                                    : from + $urandom_range(span);
                    send_write(IDX_FIELD_W'($urandom_range(31)), $urandom_range(7) != 0,
                               LANE_W'($urandom_range(lane_top)), from, to);
                end
                repeat ($urandom_range(1, 8)) begin
                    send_query(base + $urandom_range(span), $urandom_range(span), pick_skip());
                end
            end else if (kind < 8) begin
                // stacked lanes over one interval
                steps = ($urandom_range(3) == 0) ? ENTRIES_DEF : $urandom_range(1, ENTRIES_DEF);
                base  = rand_time();
                for (int i = 0; i < steps; i++) begin
                    send_write(IDX_FIELD_W'(i), 1'b1, LANE_W'(i), base, base + 100);
                end
                send_query(base + 50, 10, NO_SKIP);
                send_query(base + $urandom_range(99), $urandom_range(200),
                           IGN_W'($urandom_range(steps - 1)));
            end else begin
                repeat (6) begin
                    if ($urandom_range(1)) begin
                        send_write(IDX_FIELD_W'($urandom_range(31)), 1'($urandom_range(1)),
                                   LANE_W'($urandom_range(63)), rand_time(), rand_time());
                    end else begin
                        send_query(rand_time(), rand_time(), IGN_W'($urandom_range(63)));
                    end
                end
            end
            if (!paused_mid && items_sent >= directed_cnt + RANDOM_ITEMS / 2) begin
                wait_drained();
                paused_mid = 1'b1;
            end
        end

        wait_drained();
        repeat (ENTRIES_DEF + 8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
